// ===== src/assert_macros.svh =====
// Assertion macros shared by the lux converter RTL.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define TCLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define TCLC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/tclc_pkg.sv =====
// Shared types, widths, constants and decode functions for the lux converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tclc_pkg;

  localparam int COUNT_W  = 16;
  localparam int SQ_W     = 2 * COUNT_W;
  localparam int INTEG_W  = 3;
  localparam int GAINC_W  = 6;
  localparam int ATIME_W  = 10;
  localparam int GAIN_W   = 14;
  localparam int FA_W     = COUNT_W + ATIME_W;
  localparam int DEVF_W   = 9;
  localparam int FRAC_W   = 8;
  localparam int NUM_W    = SQ_W + DEVF_W + FRAC_W;
  localparam int DEN_W    = FA_W + GAIN_W;
  localparam int Q_W      = 27;
  localparam int LUX_W    = 27;
  localparam int STAT_W   = 2;
  localparam int CMP_W    = DEN_W + Q_W;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [COUNT_W-1:0] CH_SATURATED  = 16'hFFFF;
  localparam logic [DEVF_W-1:0]  DEVICE_FACTOR = 9'd408;
  localparam logic [LUX_W-1:0]   LUX_SAT_MAX   = 27'd68448952;
  localparam logic [INTEG_W-1:0] INTEG_RESET   = 3'd2;
  localparam logic [GAINC_W-1:0] GAINC_RESET   = 6'd16;

  typedef enum logic [STAT_W-1:0] {
    ST_VALID    = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_ZERO     = 2'd2
  } status_t;

  typedef enum logic {
    REG_INTEG = 1'b0,
    REG_GAIN  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [INTEG_W-1:0] integ_code;
    logic [GAINC_W-1:0] gain_code;
  } cfg_t;

  // Numerator, denominator and status leaving the multiplier stages.
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    status_t          status;
  } front_item_t;

  // Item travelling down the divider.
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   quo;
    logic             sat;
    status_t          status;
  } div_item_t;

  function automatic logic [ATIME_W-1:0] atime_ms(input logic [INTEG_W-1:0] code);
    logic [ATIME_W-1:0] t;
    unique case (code)
      3'd0:    t = 10'd100;
      3'd1:    t = 10'd200;
      3'd2:    t = 10'd300;
      3'd3:    t = 10'd400;
      3'd4:    t = 10'd500;
      3'd5:    t = 10'd600;
      default: t = 10'd100;
    endcase
    return t;
  endfunction

  function automatic logic [GAIN_W-1:0] gain_factor(input logic [GAINC_W-1:0] code);
    logic [GAIN_W-1:0] g;
    unique case (code)
      6'd0:    g = 14'd1;
      6'd16:   g = 14'd25;
      6'd32:   g = 14'd428;
      6'd48:   g = 14'd9876;
      default: g = 14'd1;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== src/tclc_regs.sv =====
// Configuration registers behind the APB-style port.
// Depends on tclc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tclc_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tclc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tclc_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tclc_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output tclc_pkg::cfg_t                     cfg
);
  import tclc_pkg::*;

  logic [INTEG_W-1:0] integ_r;
  logic [GAINC_W-1:0] gain_r;
  logic               wr_en;
  reg_idx_t           idx;

  // Registers sit on 4-byte boundaries; the low address bits are ignored.
  assign idx    = reg_idx_t'(paddr[2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= INTEG_RESET;
      gain_r  <= GAINC_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_INTEG: integ_r <= pwdata[INTEG_W-1:0];
        REG_GAIN:  gain_r  <= pwdata[GAINC_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_INTEG: prdata = PDATA_W'(integ_r);
      REG_GAIN:  prdata = PDATA_W'(gain_r);
      default:   prdata = '0;
    endcase
  end

  assign cfg.integ_code = integ_r;
  assign cfg.gain_code  = gain_r;

endmodule

`default_nettype wire

// ===== src/tclc_front.sv =====
// Front end: error checks, difference, and the multiplier stages that
// build the division numerator and denominator. Depends on tclc_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tclc_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tclc_pkg::cfg_t                cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tclc_pkg::COUNT_W-1:0]  in_full,
  input  wire logic [tclc_pkg::COUNT_W-1:0]  in_ir,
  output logic                               o_valid,
  input  wire logic                          o_ready,
  output tclc_pkg::front_item_t              o_item
);
  import tclc_pkg::*;

  // stage 1: status, |full - ir|, decoded time and gain
  logic               s1_valid_r;
  logic               s1_ready;
  status_t            s1_status_r, s1_status_nxt;
  logic [COUNT_W-1:0] s1_diff_r, s1_diff_nxt;
  logic [COUNT_W-1:0] s1_full_r;
  logic [ATIME_W-1:0] s1_atime_r;
  logic [GAIN_W-1:0]  s1_gain_r;
  // stage 2: diff squared, full * time
  logic               s2_valid_r;
  logic               s2_ready;
  status_t            s2_status_r;
  logic [SQ_W-1:0]    s2_sq_r;
  logic [FA_W-1:0]    s2_fa_r;
  logic [GAIN_W-1:0]  s2_gain_r;
  // stage 3: scaled numerator, full denominator
  logic               s3_valid_r;
  front_item_t        s3_item_r;
  logic [NUM_W-FRAC_W-1:0] num_hi;

  always_comb begin
    if (in_full == CH_SATURATED || in_ir == CH_SATURATED) begin
      s1_status_nxt = ST_OVERFLOW;
    end else if (in_full == '0) begin
      s1_status_nxt = ST_ZERO;
    end else begin
      s1_status_nxt = ST_VALID;
    end
    s1_diff_nxt = (in_full >= in_ir) ? (in_full - in_ir) : (in_ir - in_full);
  end

  assign in_ready = !s1_valid_r || s1_ready;
  assign s1_ready = !s2_valid_r || s2_ready;
  assign s2_ready = !s3_valid_r || o_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (s1_ready) s2_valid_r <= s1_valid_r;
      if (s2_ready) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_status_r <= s1_status_nxt;
      s1_diff_r   <= s1_diff_nxt;
      s1_full_r   <= in_full;
      s1_atime_r  <= atime_ms(cfg.integ_code);
      s1_gain_r   <= gain_factor(cfg.gain_code);
    end
    if (s1_ready && s1_valid_r) begin
      s2_status_r <= s1_status_r;
      s2_sq_r     <= SQ_W'(s1_diff_r) * SQ_W'(s1_diff_r);
      s2_fa_r     <= FA_W'(s1_full_r) * FA_W'(s1_atime_r);
      s2_gain_r   <= s1_gain_r;
    end
    if (s2_ready && s2_valid_r) begin
      s3_item_r.status <= s2_status_r;
      s3_item_r.num    <= {num_hi, {FRAC_W{1'b0}}};
      s3_item_r.den    <= DEN_W'(s2_fa_r) * DEN_W'(s2_gain_r);
    end
  end

  assign num_hi = (NUM_W - FRAC_W)'(s2_sq_r) * (NUM_W - FRAC_W)'(DEVICE_FACTOR);

  assign o_valid = s3_valid_r;
  assign o_item  = s3_item_r;

  `TCLC_ASSERT(a_den_nonzero, (s3_valid_r && s3_item_r.status == ST_VALID) |-> (s3_item_r.den != '0), "denominator zero on a good item")
  `TCLC_ASSERT_NEXT(a_s1_load, (in_valid && in_ready), s1_valid_r, "accepted transfer lost at stage 1")

endmodule

`default_nettype wire

// ===== src/tclc_div_stage.sv =====
// One restoring-division step: resolves quotient bit BIT.
// Depends on tclc_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tclc_div_stage #(
  parameter int BIT = 0
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                i_valid,
  output logic                     i_ready,
  input  wire tclc_pkg::div_item_t i_item,
  output logic                     o_valid,
  input  wire logic                o_ready,
  output tclc_pkg::div_item_t      o_item
);
  import tclc_pkg::*;

  logic             valid_r;
  div_item_t        item_r, item_nxt;
  logic [CMP_W-1:0] rem_ext;
  logic [CMP_W-1:0] dsh;
  logic [CMP_W-1:0] diff;

  assign rem_ext = CMP_W'(i_item.rem);
  assign dsh     = CMP_W'(i_item.den) << BIT;
  assign diff    = rem_ext - dsh;

  always_comb begin
    item_nxt = i_item;
    if (rem_ext >= dsh) begin
      item_nxt.rem      = diff[NUM_W-1:0];
      item_nxt.quo[BIT] = 1'b1;
    end
  end

  assign i_ready = !valid_r || o_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (i_ready) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready && i_valid) begin
      item_r <= item_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_item  = item_r;

  // remainder stays below the divisor at this weight once the bit is settled
  `TCLC_ASSERT(a_rem_bound, (valid_r && item_r.status == ST_VALID && !item_r.sat) |-> (CMP_W'(item_r.rem) < (CMP_W'(item_r.den) << BIT)), "remainder out of bound")

endmodule

`default_nettype wire

// ===== src/tclc_div.sv =====
// Pipelined divider: quotient range check, then one stage per quotient bit.
// Depends on tclc_pkg and tclc_div_stage.
`timescale 1ns / 1ps
`default_nettype none

module tclc_div (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  i_valid,
  output logic                       i_ready,
  input  wire tclc_pkg::front_item_t i_item,
  output logic                       o_valid,
  input  wire logic                  o_ready,
  output tclc_pkg::div_item_t        o_item
);
  import tclc_pkg::*;

  logic      ovf_valid_r;
  div_item_t ovf_item_r, ovf_item_nxt;

  logic      stg_valid [0:Q_W];
  logic      stg_ready [0:Q_W];
  div_item_t stg_item  [0:Q_W];

  // quotient would not fit in Q_W bits: result saturates
  always_comb begin
    ovf_item_nxt.rem    = i_item.num;
    ovf_item_nxt.den    = i_item.den;
    ovf_item_nxt.quo    = '0;
    ovf_item_nxt.status = i_item.status;
    ovf_item_nxt.sat    = CMP_W'(i_item.num) >= (CMP_W'(i_item.den) << Q_W);
  end

  assign i_ready = !ovf_valid_r || stg_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_valid_r <= 1'b0;
    end else if (i_ready) begin
      ovf_valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready && i_valid) begin
      ovf_item_r <= ovf_item_nxt;
    end
  end

  assign stg_valid[0] = ovf_valid_r;
  assign stg_item[0]  = ovf_item_r;

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    tclc_div_stage #(
      .BIT (Q_W - 1 - k)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .i_valid (stg_valid[k]),
      .i_ready (stg_ready[k]),
      .i_item  (stg_item[k]),
      .o_valid (stg_valid[k+1]),
      .o_ready (stg_ready[k+1]),
      .o_item  (stg_item[k+1])
    );
  end

  assign stg_ready[Q_W] = o_ready;
  assign o_valid        = stg_valid[Q_W];
  assign o_item         = stg_item[Q_W];

endmodule

`default_nettype wire

// ===== src/two_channel_lux_converter.sv =====
// Two-channel lux converter top level: config registers, front end,
// divider and output register. Depends on tclc_pkg and all tclc_ modules.
//
// Converts a full-spectrum and an infrared count to lux in unsigned Q8,
// floor((full-ir)^2 * 408 * 256 / (full * time_ms * gain)), saturating at
// 68448952. Status 1 flags a saturated channel (0xFFFF), status 2 a zero
// full count; lux is 0 in both cases. One pair is accepted every clock
// cycle unless in_stall is raised. The 32 register stages are three
// front-end stages (checks and difference, then two multiply stages), one
// quotient range check, 27 restoring-division stages (one quotient bit each)
// and the output register. Stalls hold the pipeline in place and empty
// stages are filled while the output waits. The user must write registers
// through the APB-style port only while no transfer is in flight; the
// block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module two_channel_lux_converter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tclc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tclc_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tclc_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tclc_pkg::COUNT_W-1:0]  in_full_count,
  input  wire logic [tclc_pkg::COUNT_W-1:0]  in_infrared_count,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [tclc_pkg::LUX_W-1:0]    out_lux_q8,
  output logic      [tclc_pkg::STAT_W-1:0]   out_status
);
  import tclc_pkg::*;

  cfg_t        cfg;
  logic        in_ready;
  logic        fr_valid, fr_ready;
  front_item_t fr_item;
  logic        dv_valid, dv_ready;
  div_item_t   dv_item;

  logic             out_valid_r;
  logic [LUX_W-1:0] lux_r, lux_nxt;
  status_t          status_r;

  tclc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tclc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_full  (in_full_count),
    .in_ir    (in_infrared_count),
    .o_valid  (fr_valid),
    .o_ready  (fr_ready),
    .o_item   (fr_item)
  );

  tclc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (fr_valid),
    .i_ready (fr_ready),
    .i_item  (fr_item),
    .o_valid (dv_valid),
    .o_ready (dv_ready),
    .o_item  (dv_item)
  );

  assign in_stall = !in_ready;
  assign dv_ready = !out_valid_r || !out_stall;

  always_comb begin
    priority if (dv_item.status != ST_VALID) begin
      lux_nxt = '0;
    end else if (dv_item.sat || dv_item.quo > LUX_SAT_MAX) begin
      lux_nxt = LUX_SAT_MAX;
    end else begin
      lux_nxt = dv_item.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dv_ready) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_ready && dv_valid) begin
      lux_r    <= lux_nxt;
      status_r <= dv_item.status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_lux_q8 = lux_r;
  assign out_status = status_r;

  `TCLC_ASSERT(a_err_zero, (out_valid_r && status_r != ST_VALID) |-> (lux_r == '0), "error transfer with nonzero lux")
  `TCLC_ASSERT(a_lux_max, out_valid_r |-> (lux_r <= LUX_SAT_MAX), "lux above saturation limit")

endmodule

`default_nettype wire

// ===== tb/tb_two_channel_lux_converter.sv =====
// Self-checking bench for two_channel_lux_converter: APB register writes,
// random valid/stall traffic on both channels, scoreboard with lux predictor.
// Depends on tclc_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_two_channel_lux_converter;
  import tclc_pkg::*;

  localparam int WATCHDOG_LIMIT   = 1000;
  localparam int DRAIN_CYCLES     = 40;
  localparam int RANDOM_PER_PHASE = 186;
  localparam int NUM_PHASES       = 9;

  // Gain and integration codes used by the test phases.
  localparam logic [GAINC_W-1:0] GC_X1    = 6'd0;
  localparam logic [GAINC_W-1:0] GC_X25   = 6'd16;
  localparam logic [GAINC_W-1:0] GC_X428  = 6'd32;
  localparam logic [GAINC_W-1:0] GC_X9876 = 6'd48;
  localparam logic [GAINC_W-1:0] GC_TOP   = 6'd63;
  localparam logic [INTEG_W-1:0] IC_100MS = 3'd0;
  localparam logic [INTEG_W-1:0] IC_600MS = 3'd5;
  localparam logic [INTEG_W-1:0] IC_TOP   = 3'd7;

  typedef struct packed {
    logic [LUX_W-1:0] lux;
    status_t          status;
  } lux_result_t;

  class lux_scoreboard;
    logic [INTEG_W-1:0] integ_code;
    logic [GAINC_W-1:0] gain_code;
    lux_result_t        expected_q[$];
    int                 errors;
    int                 matched;

    function new();
      integ_code = INTEG_RESET;
      gain_code  = GAINC_RESET;
      errors     = 0;
      matched    = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
      if (idx == REG_INTEG) begin
        integ_code = value[INTEG_W-1:0];
      end else begin
        gain_code = value[GAINC_W-1:0];
      end
    endfunction

    function lux_result_t compute_lux(logic [COUNT_W-1:0] full, logic [COUNT_W-1:0] ir);
      lux_result_t     r;
      longint unsigned f, i, diff, ms, g, num, den, q;
      f = full;
      i = ir;
      r.lux    = '0;
      r.status = ST_VALID;
      if (full == CH_SATURATED || ir == CH_SATURATED) begin
        r.status = ST_OVERFLOW;
      end else if (full == '0) begin
        r.status = ST_ZERO;
      end else begin
        diff = (f >= i) ? f - i : i - f;
        ms = (integ_code <= IC_600MS) ? (longint'(integ_code) + 1) * 100 : 100;
        case (gain_code)
          GC_X25:   g = 25;
          GC_X428:  g = 428;
          GC_X9876: g = 9876;
          default:  g = 1;
        endcase
        num = diff * diff * 408 * 256;
        den = f * ms * g;
        q = num / den;
        if (q > longint'(LUX_SAT_MAX)) q = LUX_SAT_MAX;
        r.lux = q[LUX_W-1:0];
      end
      return r;
    endfunction

    function void note_pair(logic [COUNT_W-1:0] full, logic [COUNT_W-1:0] ir);
      expected_q.push_back(compute_lux(full, ir));
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [LUX_W-1:0] lux, logic [STAT_W-1:0] status);
      lux_result_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result lux=%0d status=%0d", lux, status));
      end else begin
        exp = expected_q.pop_front();
        if (lux !== exp.lux || status !== exp.status) begin
          report_mismatch($sformatf("lux=%0d status=%0d, expected lux=%0d status=%0d",
                                    lux, status, exp.lux, exp.status));
        end else begin
          matched++;
        end
      end
    endtask

    task check_drained();
      if (expected_q.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [COUNT_W-1:0]   in_full_count = '0;
  logic [COUNT_W-1:0]   in_infrared_count = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [LUX_W-1:0]     out_lux_q8;
  logic [STAT_W-1:0]    out_status;

  lux_scoreboard sb;
  bit            quiet = 1'b0;
  int            stall_left = 0;
  int            idle_cycles = 0;
  int            pairs_in = 0;
  int            settings_run = 1;

  two_channel_lux_converter uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_full_count     (in_full_count),
    .in_infrared_count (in_infrared_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_lux_q8        (out_lux_q8),
    .out_status        (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver backpressure in random bursts.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Transfer monitor and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_pair(in_full_count, in_infrared_count);
        pairs_in++;
      end
      if (out_valid && !out_stall) sb.check_result(out_lux_q8, out_status);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_pair(input logic [COUNT_W-1:0] full, input logic [COUNT_W-1:0] ir);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_full_count     <= full;
    in_infrared_count <= ir;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait for every expected result.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Upper bits of the write data carry junk; only the field width is kept.
  task automatic apply_setting(input logic [INTEG_W-1:0] integ, input logic [GAINC_W-1:0] gain);
    drain();
    cfg_write(REG_INTEG, ($urandom() & 32'hFFFF_FFF8) | {29'd0, integ});
    cfg_write(REG_GAIN, ($urandom() & 32'hFFFF_FFC0) | {26'd0, gain});
    settings_run++;
  endtask

  function automatic void pick_counts(output logic [COUNT_W-1:0] full,
                                      output logic [COUNT_W-1:0] ir);
    case ($urandom_range(0, 9))
      0: begin full = CH_SATURATED; ir = COUNT_W'($urandom()); end
      1: begin full = COUNT_W'($urandom()); ir = CH_SATURATED; end
      2: begin full = '0; ir = COUNT_W'($urandom()); end
      3: begin full = COUNT_W'($urandom_range(1, 255)); ir = COUNT_W'($urandom()); end
      4: begin full = COUNT_W'($urandom()); ir = full ^ COUNT_W'($urandom_range(0, 255)); end
      default: begin full = COUNT_W'($urandom()); ir = COUNT_W'($urandom()); end
    endcase
  endfunction

  logic [COUNT_W-1:0] directed_full [18] = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000,
                                             16'h0001, 16'h0001, 16'hFFFE, 16'hFFFE, 16'h0064,
                                             16'h000A, 16'h1388, 16'hFFFE, 16'h8000, 16'h0001,
                                             16'hAAAA, 16'h5555, 16'h7FFF};
  logic [COUNT_W-1:0] directed_ir   [18] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h04D2,
                                             16'h0000, 16'hFFFE, 16'h0000, 16'hFFFE, 16'h0064,
                                             16'h1388, 16'h000A, 16'h0001, 16'h7FFF, 16'h0001,
                                             16'h5555, 16'hAAAA, 16'h8000};
  logic [INTEG_W-1:0] phase_integ [NUM_PHASES] = '{IC_TOP, IC_600MS, 3'd6, 3'd3, 3'd1,
                                                   3'd4, IC_100MS, 3'd0, INTEG_RESET};
  logic [GAINC_W-1:0] phase_gain  [NUM_PHASES] = '{GC_X9876, GC_X9876, GC_TOP, GC_X428, 6'd1,
                                                   GC_X25, GC_X1, 6'd0, GAINC_RESET};

  initial begin
    logic [COUNT_W-1:0] full, ir;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: saturated channels, zero full, ir above, equal to and below full.
    foreach (directed_full[k]) send_pair(directed_full[k], directed_ir[k]);

    // Shortest time and unit gain: largest lux, clamp to the maximum.
    apply_setting(IC_100MS, GC_X1);
    send_pair(16'h0001, 16'h0000);
    send_pair(16'h0002, 16'h0001);
    send_pair(16'h012C, 16'h0000);
    send_pair(16'hFFFE, 16'h0000);
    send_pair(16'h0001, 16'hFFFE);
    send_pair(16'h0028, 16'hFFFE);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 2) begin
        apply_setting(INTEG_W'($urandom_range(0, 7)), GAINC_W'($urandom_range(0, 63)));
      end else begin
        apply_setting(phase_integ[p], phase_gain[p]);
      end
      quiet = (p == NUM_PHASES - 1);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick_counts(full, ir);
        send_pair(full, ir);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d count pairs under %0d register settings; %0d results matched.",
             pairs_in, settings_run, sb.matched);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/tclc_pkg.sv
src/tclc_regs.sv
src/tclc_front.sv
src/tclc_div_stage.sv
src/tclc_div.sv
src/two_channel_lux_converter.sv
tb/tb_two_channel_lux_converter.sv
